@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHECK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");

// Check that a condition holds in the cycle after a trigger.
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ hw/rtl/kccf_pkg.sv @@
package kccf_pkg;

  localparam int PROB_BITS  = 16;
  localparam int COUNT_BITS = 8;

  localparam int CFG_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 8;
  localparam int THR_W  = 7;
  localparam int PCT_W  = 7;
  localparam int CLS_W  = 3;
  localparam int CODE_W = 4;

  localparam int MEAN_W = PROB_BITS + 1;
  localparam int MUL_W  = PROB_BITS + 7;
  // dividend of the mean step: 2*|d| + n
  localparam int MDIV_W = ((PROB_BITS + 2 > COUNT_BITS) ? PROB_BITS + 2 : COUNT_BITS) + 1;
  // dividend of the percent step: mean*100 + max
  localparam int PDIV_W = PROB_BITS + 8;
  localparam int DVD_W  = (MDIV_W > PDIV_W) ? MDIV_W : PDIV_W;
  localparam int DVS_W  = (COUNT_BITS > PROB_BITS) ? COUNT_BITS + 1 : PROB_BITS + 1;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam logic [PROB_BITS-1:0]  PROB_MAX  = {PROB_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PCT_W-1:0]      PCT_CAP   = 7'd100;

  localparam logic [CLS_W-1:0] CLS_OFF     = 3'd0;
  localparam logic [CLS_W-1:0] CLS_ON      = 3'd1;
  localparam logic [CLS_W-1:0] CLS_OTHER   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_SILENCE = 3'd3;
  localparam logic [CLS_W-1:0] CLS_SWITCH  = 3'd4;

  localparam logic [IDX_W-1:0] REG_COUNT_OFF     = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_ON      = 3'd1;
  localparam logic [IDX_W-1:0] REG_COUNT_OTHER   = 3'd2;
  localparam logic [IDX_W-1:0] REG_COUNT_SILENCE = 3'd3;
  localparam logic [IDX_W-1:0] REG_COUNT_SWITCH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESH_OFF    = 3'd5;
  localparam logic [IDX_W-1:0] REG_THRESH_ON     = 3'd6;
  localparam logic [IDX_W-1:0] REG_THRESH_SWITCH = 3'd7;

endpackage

@@ hw/rtl/keyword_class_confirmation_filter_unit.sv @@
// Confirms keyword commands from a stream of classifier frames, one frame at a time.
// in_ready is high only while the block is idle. A frame that misses or is a blocked
// repeat goes from ST_EVAL straight to ST_DONE; a passing frame runs the running-mean
// division in ST_DIV and the update in ST_MEAN, and a confirming frame runs ST_DIV
// again for the percent conversion, because the running-mean update and the percent
// conversion share one restoring divider that retires one quotient bit per cycle.
// The result sits in an output register, so the next frame is accepted while it
// waits. Configuration writes take effect at once and must only be issued while idle.
`include "assert_macros.svh"

module keyword_class_confirmation_filter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kccf_pkg::IDX_W-1:0]         cfg_index,
  input  logic [kccf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kccf_pkg::CODE_W-1:0]        class_code,
  input  logic [kccf_pkg::PROB_BITS-1:0]     prob_q16,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               detected,
  output logic [kccf_pkg::CLS_W-1:0]         command_class,
  output logic [kccf_pkg::PCT_W-1:0]         confidence_pct
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MEAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [kccf_pkg::CNT_W-1:0] count_off, count_on, count_other, count_silence, count_switch;
  logic [kccf_pkg::THR_W-1:0] thresh_off, thresh_on, thresh_switch;

  logic                              wait_change;
  logic [kccf_pkg::CLS_W-1:0]        blocked_code;
  logic                              streak_active;
  logic [kccf_pkg::CLS_W-1:0]        streak_code;
  logic [kccf_pkg::COUNT_BITS-1:0]   streak_count;
  logic [kccf_pkg::MEAN_W-1:0]       streak_mean;
  logic [kccf_pkg::CLS_W-1:0]        miss_code;
  logic [kccf_pkg::COUNT_BITS-1:0]   miss_count;

  logic [kccf_pkg::CLS_W-1:0]        cls;
  logic [kccf_pkg::PROB_BITS-1:0]    prob;
  logic                              d_neg;
  logic                              op_pct;

  logic [kccf_pkg::DVD_W-1:0]        dvd;
  logic [kccf_pkg::DVD_W-1:0]        quo;
  logic [kccf_pkg::DVS_W-1:0]        rem;
  logic [kccf_pkg::DVS_W-1:0]        divisor;
  logic [kccf_pkg::STEP_W-1:0]       step_cnt;

  logic                              res_det;
  logic [kccf_pkg::CLS_W-1:0]        res_cls;
  logic [kccf_pkg::PCT_W-1:0]        res_pct;

  // frame evaluation
  logic [kccf_pkg::CNT_W-1:0]        needed;
  logic [kccf_pkg::THR_W-1:0]        thresh;
  logic                              is_cmd, passes, blocked;
  logic [kccf_pkg::MUL_W-1:0]        p_x100, t_xm;
  logic [kccf_pkg::COUNT_BITS-1:0]   miss_base, miss_run;
  logic                              miss_full;
  logic                              fresh;
  logic [kccf_pkg::COUNT_BITS-1:0]   cnt_base, cnt_new;
  logic [kccf_pkg::MEAN_W-1:0]       mean_base, two_p, mag;
  logic                              neg;
  logic [kccf_pkg::MDIV_W-1:0]       mdvd;

  // divider step and finish
  logic [kccf_pkg::DVS_W:0]          rem_sh, rem_nx;
  logic                              take;
  logic [kccf_pkg::MEAN_W-1:0]       q_mean, mean_upd;
  logic                              hit;
  logic [kccf_pkg::PDIV_W-1:0]       pdvd;
  logic [kccf_pkg::PCT_W-1:0]        pct_final;
  logic                              detect_ok;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    case (cls)
      kccf_pkg::CLS_OFF:     needed = count_off;
      kccf_pkg::CLS_ON:      needed = count_on;
      kccf_pkg::CLS_OTHER:   needed = count_other;
      kccf_pkg::CLS_SILENCE: needed = count_silence;
      default:               needed = count_switch;
    endcase
    case (cls)
      kccf_pkg::CLS_OFF: thresh = thresh_off;
      kccf_pkg::CLS_ON:  thresh = thresh_on;
      default:           thresh = thresh_switch;
    endcase
  end

  assign is_cmd  = (cls != kccf_pkg::CLS_OTHER) && (cls != kccf_pkg::CLS_SILENCE);
  assign p_x100  = kccf_pkg::MUL_W'(prob) * kccf_pkg::MUL_W'(100);
  assign t_xm    = (kccf_pkg::MUL_W'(thresh) << kccf_pkg::PROB_BITS) - kccf_pkg::MUL_W'(thresh);
  assign passes  = is_cmd && ((thresh == '0) || (p_x100 >= t_xm));
  assign blocked = wait_change && (cls == blocked_code);

  // restart the miss run when the class changes
  assign miss_base = ((miss_count == '0) || (miss_code != cls)) ? '0 : miss_count;
  assign miss_run  = (miss_base == kccf_pkg::COUNT_MAX) ? miss_base : miss_base + 1'b1;
  assign miss_full = 32'(miss_run) >= 32'(needed);

  assign fresh     = !streak_active || (cls != streak_code);
  assign cnt_base  = fresh ? '0 : streak_count;
  assign cnt_new   = (cnt_base == kccf_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
  assign mean_base = fresh ? '0 : streak_mean;
  assign two_p     = {prob, 1'b0};
  assign neg       = two_p < mean_base;
  assign mag       = neg ? mean_base - two_p : two_p - mean_base;
  // round to nearest: (2*|d| + n) / (2*n)
  assign mdvd      = (kccf_pkg::MDIV_W'(mag) << 1) + kccf_pkg::MDIV_W'(cnt_new);

  assign rem_sh = {rem, dvd[kccf_pkg::DVD_W-1]};
  assign take   = rem_sh >= {1'b0, divisor};
  assign rem_nx = take ? rem_sh - {1'b0, divisor} : rem_sh;

  assign q_mean    = quo[kccf_pkg::MEAN_W-1:0];
  assign mean_upd  = d_neg ? streak_mean - q_mean : streak_mean + q_mean;
  assign hit       = 32'(streak_count) >= 32'(needed);
  assign pdvd      = kccf_pkg::PDIV_W'(mean_upd) * kccf_pkg::PDIV_W'(100)
                   + kccf_pkg::PDIV_W'(kccf_pkg::PROB_MAX);
  assign pct_final = (quo > kccf_pkg::DVD_W'(kccf_pkg::PCT_CAP)) ? kccf_pkg::PCT_CAP
                                                              : quo[kccf_pkg::PCT_W-1:0];

  assign detect_ok = (confidence_pct <= kccf_pkg::PCT_CAP)
                   && ((command_class == kccf_pkg::CLS_OFF)
                       || (command_class == kccf_pkg::CLS_ON)
                       || (command_class == kccf_pkg::CLS_SWITCH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_off     <= 8'd2;
      count_on      <= 8'd2;
      count_other   <= 8'd4;
      count_silence <= 8'd4;
      count_switch  <= 8'd2;
      thresh_off    <= '0;
      thresh_on     <= '0;
      thresh_switch <= '0;
      wait_change   <= 1'b0;
      blocked_code  <= kccf_pkg::CLS_OFF;
      streak_active <= 1'b0;
      streak_code   <= kccf_pkg::CLS_OFF;
      streak_count  <= '0;
      streak_mean   <= '0;
      miss_code     <= kccf_pkg::CLS_OFF;
      miss_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kccf_pkg::REG_COUNT_OFF:     count_off     <= cfg_data;
          kccf_pkg::REG_COUNT_ON:      count_on      <= cfg_data;
          kccf_pkg::REG_COUNT_OTHER:   count_other   <= cfg_data;
          kccf_pkg::REG_COUNT_SILENCE: count_silence <= cfg_data;
          kccf_pkg::REG_COUNT_SWITCH:  count_switch  <= cfg_data;
          kccf_pkg::REG_THRESH_OFF:    thresh_off    <= cfg_data[kccf_pkg::THR_W-1:0];
          kccf_pkg::REG_THRESH_ON:     thresh_on     <= cfg_data[kccf_pkg::THR_W-1:0];
          kccf_pkg::REG_THRESH_SWITCH: thresh_switch <= cfg_data[kccf_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      // ST_DONE loads the output register itself
      if (out_valid && out_ready && (state != ST_DONE)) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cls   <= (class_code > kccf_pkg::CODE_W'(kccf_pkg::CLS_SWITCH))
                   ? kccf_pkg::CLS_OTHER : class_code[kccf_pkg::CLS_W-1:0];
            prob  <= prob_q16;
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          res_det <= 1'b0;
          res_cls <= kccf_pkg::CLS_OFF;
          res_pct <= '0;
          if (blocked) begin
            state <= ST_DONE;
          end else begin
            wait_change <= 1'b0;
            if (!passes) begin
              if (is_cmd || miss_full) begin
                streak_active <= 1'b0;
                streak_count  <= '0;
                streak_mean   <= '0;
              end
              if (miss_full) begin
                miss_count <= '0;
                miss_code  <= kccf_pkg::CLS_OFF;
              end else begin
                miss_count <= miss_run;
                miss_code  <= cls;
              end
              state <= ST_DONE;
            end else begin
              miss_count <= '0;
              if (fresh) begin
                streak_active <= 1'b1;
                streak_code   <= cls;
                miss_code     <= kccf_pkg::CLS_OFF;
              end
              streak_count <= cnt_new;
              streak_mean  <= mean_base;
              d_neg        <= neg;
              dvd          <= kccf_pkg::DVD_W'(mdvd) << (kccf_pkg::DVD_W - kccf_pkg::MDIV_W);
              rem          <= '0;
              quo          <= '0;
              divisor      <= kccf_pkg::DVS_W'({cnt_new, 1'b0});
              step_cnt     <= kccf_pkg::STEP_W'(kccf_pkg::MDIV_W);
              op_pct       <= 1'b0;
              state        <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (step_cnt != '0) begin
            rem      <= rem_nx[kccf_pkg::DVS_W-1:0];
            quo      <= {quo[kccf_pkg::DVD_W-2:0], take};
            dvd      <= dvd << 1;
            step_cnt <= step_cnt - 1'b1;
          end else if (op_pct) begin
            res_det <= 1'b1;
            res_cls <= cls;
            res_pct <= pct_final;
            state   <= ST_DONE;
          end else begin
            state <= ST_MEAN;
          end
        end

        ST_MEAN: begin
          if (!hit) begin
            streak_mean <= mean_upd;
            state       <= ST_DONE;
          end else begin
            // confirmed: clear the streak, block repeats, convert the mean to percent
            streak_active <= 1'b0;
            streak_count  <= '0;
            streak_mean   <= '0;
            miss_count    <= '0;
            miss_code     <= kccf_pkg::CLS_OFF;
            wait_change   <= 1'b1;
            blocked_code  <= cls;
            dvd           <= kccf_pkg::DVD_W'(pdvd) << (kccf_pkg::DVD_W - kccf_pkg::PDIV_W);
            rem           <= '0;
            quo           <= '0;
            divisor       <= kccf_pkg::DVS_W'({kccf_pkg::PROB_MAX, 1'b0});
            step_cnt      <= kccf_pkg::STEP_W'(kccf_pkg::PDIV_W);
            op_pct        <= 1'b1;
            state         <= ST_DIV;
          end
        end

        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            detected       <= res_det;
            command_class  <= res_cls;
            confidence_pct <= res_pct;
            state          <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `CHECK_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `CHECK_ALWAYS(a_div_nonzero, clk, rst, state != ST_DIV || divisor != '0)
  `CHECK_ALWAYS(a_streak_count, clk, rst, !streak_active || streak_count != '0)
  `CHECK_ALWAYS(a_wait_clean, clk, rst, !wait_change || (!streak_active && miss_count == '0))
  `CHECK_ALWAYS(a_detect_sane, clk, rst, !(out_valid && detected) || detect_ok)

endmodule

@@ sim/keyword_class_confirmation_filter_unit_test.sv @@
`timescale 1ns / 1ps

module keyword_class_confirmation_filter_unit_test;

  localparam int NUM_REGS = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic                           detected;
    logic [kccf_pkg::CLS_W-1:0]     cls;
    logic [kccf_pkg::PCT_W-1:0]     pct;
  } verdict_t;

  typedef struct packed {
    logic [kccf_pkg::CODE_W-1:0]    code;
    logic [kccf_pkg::PROB_BITS-1:0] prob;
  } frame_t;

  typedef logic [kccf_pkg::CFG_W-1:0] reg_set_t [NUM_REGS];

  class detection_tracker;
    logic [kccf_pkg::CNT_W-1:0]      need_of [5];
    logic [kccf_pkg::THR_W-1:0]      thr_off, thr_on, thr_switch;
    logic                            hold_on;
    logic [kccf_pkg::CLS_W-1:0]      hold_class;
    logic                            run_on;
    logic [kccf_pkg::CLS_W-1:0]      run_class;
    logic [kccf_pkg::COUNT_BITS-1:0] run_len;
    logic [kccf_pkg::MEAN_W-1:0]     run_mean;
    logic [kccf_pkg::CLS_W-1:0]      miss_class;
    logic [kccf_pkg::COUNT_BITS-1:0] miss_len;
    verdict_t                        pending_verdicts[$];
    int                              errors;

    function new();
      need_of = '{8'd2, 8'd2, 8'd4, 8'd4, 8'd2};
      thr_off = '0;
      thr_on = '0;
      thr_switch = '0;
      hold_on = 1'b0;
      hold_class = '0;
      run_on = 1'b0;
      run_class = '0;
      run_len = '0;
      run_mean = '0;
      miss_class = '0;
      miss_len = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [kccf_pkg::IDX_W-1:0] idx,
                            logic [kccf_pkg::CFG_W-1:0] data);
      case (idx)
        kccf_pkg::REG_COUNT_OFF:     need_of[kccf_pkg::CLS_OFF] = data;
        kccf_pkg::REG_COUNT_ON:      need_of[kccf_pkg::CLS_ON] = data;
        kccf_pkg::REG_COUNT_OTHER:   need_of[kccf_pkg::CLS_OTHER] = data;
        kccf_pkg::REG_COUNT_SILENCE: need_of[kccf_pkg::CLS_SILENCE] = data;
        kccf_pkg::REG_COUNT_SWITCH:  need_of[kccf_pkg::CLS_SWITCH] = data;
        kccf_pkg::REG_THRESH_OFF:    thr_off = data[kccf_pkg::THR_W-1:0];
        kccf_pkg::REG_THRESH_ON:     thr_on = data[kccf_pkg::THR_W-1:0];
        kccf_pkg::REG_THRESH_SWITCH: thr_switch = data[kccf_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void drop_run();
      run_on = 1'b0;
      run_len = '0;
      run_mean = '0;
    endfunction

    // Advance the filter state by one frame and queue the verdict it yields.
    function void take_frame(logic [kccf_pkg::CODE_W-1:0] code,
                             logic [kccf_pkg::PROB_BITS-1:0] prob);
      logic [kccf_pkg::CLS_W-1:0] c;
      logic [kccf_pkg::CNT_W-1:0] need;
      logic [kccf_pkg::THR_W-1:0] t;
      logic                       cmd, pass;
      longint                     d, mag, q, n, pct;
      pending_verdicts.push_back('0);
      c = (code > kccf_pkg::CODE_W'(kccf_pkg::CLS_SWITCH)) ? kccf_pkg::CLS_OTHER
                                                          : code[kccf_pkg::CLS_W-1:0];
      need = need_of[c];
      cmd = (c != kccf_pkg::CLS_OTHER) && (c != kccf_pkg::CLS_SILENCE);
      t = (c == kccf_pkg::CLS_OFF) ? thr_off : (c == kccf_pkg::CLS_ON) ? thr_on : thr_switch;
      pass = cmd && (t == 0 ||
                     longint'(prob) * 100 >= longint'(t) * longint'(kccf_pkg::PROB_MAX));
      if (hold_on) begin
        if (c == hold_class) return;
        hold_on = 1'b0;
      end
      if (!pass) begin
        if (cmd) drop_run();
        if (miss_len == 0 || miss_class != c) begin
          miss_class = c;
          miss_len = '0;
        end
        if (miss_len != kccf_pkg::COUNT_MAX) miss_len++;
        if (miss_len >= need) begin
          drop_run();
          miss_len = '0;
          miss_class = '0;
        end
        return;
      end
      miss_len = '0;
      if (!run_on || c != run_class) begin
        run_on = 1'b1;
        run_class = c;
        run_len = '0;
        run_mean = '0;
        miss_class = '0;
      end
      if (run_len != kccf_pkg::COUNT_MAX) run_len++;
      n = longint'(run_len);
      d = 2 * longint'(prob) - longint'(run_mean);
      mag = (d < 0) ? -d : d;
      // round half away from zero
      q = (mag * 2 + n) / (2 * n);
      if (d < 0) q = -q;
      run_mean = kccf_pkg::MEAN_W'(longint'(run_mean) + q);
      if (run_len < need) return;
      pct = (longint'(run_mean) * 100 + longint'(kccf_pkg::PROB_MAX))
            / (2 * longint'(kccf_pkg::PROB_MAX));
      if (pct > longint'(kccf_pkg::PCT_CAP)) pct = longint'(kccf_pkg::PCT_CAP);
      drop_run();
      miss_len = '0;
      miss_class = '0;
      hold_on = 1'b1;
      hold_class = c;
      pending_verdicts[pending_verdicts.size() - 1] = '{1'b1, c, kccf_pkg::PCT_W'(pct)};
    endfunction

    function void match_verdict(logic det, logic [kccf_pkg::CLS_W-1:0] cls,
                                logic [kccf_pkg::PCT_W-1:0] pct);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got detected=%0d class=%0d pct=%0d",
                 $time, det, cls, pct);
        return;
      end
      want = pending_verdicts.pop_front();
      if (det !== want.detected || cls !== want.cls || pct !== want.pct) begin
        errors++;
        $display("%0t: mismatch expected detected=%0d class=%0d pct=%0d,",
                 $time, want.detected, want.cls, want.pct,
                 " got detected=%0d class=%0d pct=%0d", det, cls, pct);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [kccf_pkg::IDX_W-1:0]      cfg_index = '0;
  logic [kccf_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [kccf_pkg::CODE_W-1:0]     class_code = '0;
  logic [kccf_pkg::PROB_BITS-1:0]  prob_q16 = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            detected;
  logic [kccf_pkg::CLS_W-1:0]      command_class;
  logic [kccf_pkg::PCT_W-1:0]      confidence_pct;

  detection_tracker tracker = new;
  frame_t   frames_to_send[$];
  reg_set_t cur_regs = '{8'd2, 8'd2, 8'd4, 8'd4, 8'd2, 8'd0, 8'd0, 8'd0};
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_left = 0;
  int       quiet_cycles = 0;
  bit       long_run_sent = 1'b0;

  keyword_class_confirmation_filter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .class_code     (class_code),
    .prob_q16       (prob_q16),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .detected       (detected),
    .command_class  (command_class),
    .confidence_pct (confidence_pct)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Frame sender: hold the payload until the transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_frame(class_code, prob_q16);
      if (!in_valid || in_ready) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {class_code, prob_q16} <= frames_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.match_verdict(detected, command_class, confidence_pct);
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [kccf_pkg::PROB_BITS-1:0] streak_prob(
      logic [kccf_pkg::THR_W-1:0] t);
    int unsigned lo;
    if (t > 100) return kccf_pkg::PROB_BITS'($urandom);
    lo = (int'(t) * int'(kccf_pkg::PROB_MAX) + 99) / 100;
    case ($urandom_range(9))
      0: return kccf_pkg::PROB_BITS'(lo);
      1: return kccf_pkg::PROB_MAX;
      2: return (lo > 0) ? kccf_pkg::PROB_BITS'(lo - 1) : kccf_pkg::PROB_BITS'($urandom);
      default: return kccf_pkg::PROB_BITS'($urandom_range(int'(kccf_pkg::PROB_MAX), lo));
    endcase
  endfunction

  function automatic frame_t noise_frame();
    logic [kccf_pkg::PROB_BITS-1:0] p;
    case ($urandom_range(3))
      0: p = '0;
      1: p = kccf_pkg::PROB_MAX;
      default: p = kccf_pkg::PROB_BITS'($urandom);
    endcase
    return {kccf_pkg::CODE_W'($urandom_range(15)), p};
  endfunction

  // One command-class streak, near its confirm count up to 12, then noise.
  function automatic void add_burst();
    logic [kccf_pkg::CLS_W-1:0] c;
    logic [kccf_pkg::CNT_W-1:0] need;
    logic [kccf_pkg::THR_W-1:0] t;
    int                         len;
    case ($urandom_range(2))
      0: begin
        c = kccf_pkg::CLS_OFF;
        need = cur_regs[kccf_pkg::REG_COUNT_OFF];
        t = cur_regs[kccf_pkg::REG_THRESH_OFF][kccf_pkg::THR_W-1:0];
      end
      1: begin
        c = kccf_pkg::CLS_ON;
        need = cur_regs[kccf_pkg::REG_COUNT_ON];
        t = cur_regs[kccf_pkg::REG_THRESH_ON][kccf_pkg::THR_W-1:0];
      end
      default: begin
        c = kccf_pkg::CLS_SWITCH;
        need = cur_regs[kccf_pkg::REG_COUNT_SWITCH];
        t = cur_regs[kccf_pkg::REG_THRESH_SWITCH][kccf_pkg::THR_W-1:0];
      end
    endcase
    if (need > 12) begin
      if (!long_run_sent && $urandom_range(3) == 0) begin
        len = int'(need) + 1;
        long_run_sent = 1'b1;
      end else begin
        len = $urandom_range(8, 1);
      end
    end else begin
      len = $urandom_range(int'(need) + 2, (need > 1) ? int'(need) - 1 : 1);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) frames_to_send.push_back(noise_frame());
      frames_to_send.push_back({kccf_pkg::CODE_W'(c), streak_prob(t)});
    end
    repeat ($urandom_range(3)) frames_to_send.push_back(noise_frame());
  endfunction

  task automatic program_regs(reg_set_t s);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= kccf_pkg::IDX_W'(i);
      cfg_data <= s[i];
      tracker.write_reg(kccf_pkg::IDX_W'(i), s[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_regs = s;
  endtask

  task automatic drain();
    while (frames_to_send.size() != 0 || in_valid || tracker.pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  function automatic void push_frame(logic [kccf_pkg::CLS_W-1:0] c,
                                     logic [kccf_pkg::PROB_BITS-1:0] p);
    frames_to_send.push_back({kccf_pkg::CODE_W'(c), p});
  endfunction

  initial begin
    reg_set_t s;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    push_frame(kccf_pkg::CLS_ON, kccf_pkg::PROB_MAX);
    push_frame(kccf_pkg::CLS_ON, kccf_pkg::PROB_MAX);
    push_frame(kccf_pkg::CLS_ON, '0);          // repeat of the detected class
    push_frame(kccf_pkg::CLS_OFF, '0);
    push_frame(kccf_pkg::CLS_OFF, '0);
    push_frame(kccf_pkg::CLS_OFF, kccf_pkg::PROB_MAX);
    frames_to_send.push_back({4'hF, kccf_pkg::PROB_MAX});
    frames_to_send.push_back({4'h5, 16'h0000});
    push_frame(kccf_pkg::CLS_OTHER, 16'h1234);
    frames_to_send.push_back({4'h8, 16'hFFFF});
    push_frame(kccf_pkg::CLS_SWITCH, 16'd1);
    push_frame(kccf_pkg::CLS_SWITCH, 16'hFFFE);
    push_frame(kccf_pkg::CLS_SILENCE, '0);
    push_frame(kccf_pkg::CLS_SILENCE, kccf_pkg::PROB_MAX);
    push_frame(kccf_pkg::CLS_ON, 16'h8000);
    push_frame(kccf_pkg::CLS_SILENCE, 16'h5555);
    push_frame(kccf_pkg::CLS_ON, 16'h7FFF);
    push_frame(kccf_pkg::CLS_OFF, 16'd40000);
    push_frame(kccf_pkg::CLS_SWITCH, 16'd40000);
    push_frame(kccf_pkg::CLS_SWITCH, 16'd12345);
    frames_to_send.push_back({4'hA, 16'hAAAA});
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: s = '{8'd2, 8'd2, 8'd4, 8'd4, 8'd2, 8'd0, 8'd0, 8'd0};
        1: s = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd100, 8'd100, 8'd100};
        2: s = '{8'd1, 8'd3, 8'd1, 8'd2, 8'd5, 8'd50, 8'd20, 8'd80};
        3: s = '{8'd255, 8'd4, 8'd255, 8'd255, 8'd3, 8'd0, 8'd127, 8'd1};
        4: s = '{8'd3, 8'd3, 8'd6, 8'd2, 8'd3, 8'd30, 8'd60, 8'd90};
        5: s = '{8'd6, 8'd1, 8'd3, 8'd7, 8'd2, 8'h8A, 8'h80, 8'd45};
        8: s = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd255, 8'd100, 8'd5, 8'd0};
        default: begin
          for (int i = 0; i < NUM_REGS; i++) s[i] = kccf_pkg::CFG_W'($urandom_range(8));
          s[kccf_pkg::REG_THRESH_OFF] = kccf_pkg::CFG_W'($urandom);
          s[kccf_pkg::REG_THRESH_ON] = kccf_pkg::CFG_W'($urandom);
          s[kccf_pkg::REG_THRESH_SWITCH] = kccf_pkg::CFG_W'($urandom);
        end
      endcase
      repeat (4) @(posedge clk);
      program_regs(s);
      case (ph / 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      long_run_sent = 1'b0;
      // two batches; the sender waits for every result in between
      for (int b = 0; b < 2; b++) begin
        @(negedge clk);
        while (frames_to_send.size() < 65) add_burst();
        if (b == 1 && (ph == 0 || ph == 5)) stall_left = 400;
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               tracker.pending_verdicts.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/kccf_pkg.sv
hw/rtl/keyword_class_confirmation_filter_unit.sv
sim/keyword_class_confirmation_filter_unit_test.sv
